// ----- rtl/core/grid_rms_convergence_ratio_top_assert.svh -----
// Assertion macros shared by the RTL. Each expects clk and rst_n in scope.
`ifndef GRID_RMS_CONVERGENCE_RATIO_TOP_ASSERT_SVH
`define GRID_RMS_CONVERGENCE_RATIO_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GRC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/grc_pkg.sv -----
package grc_pkg;

  localparam int SAMPLE_BITS_DEF = 24;
  localparam int MAX_POINTS_DEF  = 4096;

  localparam int SUM_W    = 64;
  localparam int HALF_W   = 32;
  localparam int RATIO_W  = 32;
  localparam int STATUS_W = 2;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DEN_ZERO = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;

  localparam logic [RATIO_W-1:0] RATIO_MAX = '1;

  // Datapath operations issued by the controller.
  localparam logic [2:0] OP_NOP       = 3'd0;
  localparam logic [2:0] OP_MUL       = 3'd1;
  localparam logic [2:0] OP_DIV_INIT  = 3'd2;
  localparam logic [2:0] OP_DIV_STEP  = 3'd3;
  localparam logic [2:0] OP_SQRT_STEP = 3'd4;
  localparam logic [2:0] OP_EMIT      = 3'd5;

  // Partial products of the cross multiplication.
  localparam logic [1:0] MSEL_S0_LO = 2'd0;
  localparam logic [1:0] MSEL_S0_HI = 2'd1;
  localparam logic [1:0] MSEL_S1_LO = 2'd2;
  localparam logic [1:0] MSEL_S1_HI = 2'd3;

  localparam int MUL_STEPS  = 4;
  localparam int DIV_STEPS  = 64;
  localparam int SQRT_STEPS = 32;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  typedef struct packed {
    logic       push;
    logic [2:0] op;
    logic [1:0] mul_sel;
  } grc_cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic empty;
    logic s0_zero;
    logic s1_zero;
  } grc_acc_sts_t;

endpackage

// ----- rtl/core/grc_accum.sv -----
module grc_accum #(
  parameter int SAMPLE_BITS = grc_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_POINTS  = grc_pkg::MAX_POINTS_DEF,
  localparam int CNT_W      = $clog2(MAX_POINTS + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  grc_pkg::grc_cmd_t             cmd,
  input  logic                          in_set_sel,
  input  logic signed [SAMPLE_BITS-1:0] in_coarse_val,
  input  logic signed [SAMPLE_BITS-1:0] in_fine_val,
  output logic [grc_pkg::SUM_W-1:0]     sum0,
  output logic [grc_pkg::SUM_W-1:0]     sum1,
  output logic [CNT_W-1:0]              cnt0,
  output logic [CNT_W-1:0]              cnt1,
  output grc_pkg::grc_acc_sts_t         acc_sts
);
  import grc_pkg::*;

  logic signed [SAMPLE_BITS:0] diff;
  logic [SAMPLE_BITS:0]        mag_full;

  logic                     v1_r, set1_r;
  logic [SAMPLE_BITS-1:0]   mag1_r;
  logic                     v2_r, set2_r;
  logic [2*SAMPLE_BITS-1:0] sq2_r;

  logic [SUM_W-1:0] sum0_r, sum0_nxt, sum1_r, sum1_nxt;
  logic [CNT_W-1:0] cnt0_r, cnt0_nxt, cnt1_r, cnt1_nxt;
  logic [SUM_W-1:0] sum_sel, sum_sat;
  logic [SUM_W:0]   sum_add;
  logic [CNT_W-1:0] cnt_sel;
  logic             room;

  assign diff = $signed({in_coarse_val[SAMPLE_BITS-1], in_coarse_val})
              - $signed({in_fine_val[SAMPLE_BITS-1], in_fine_val});
  assign mag_full = diff[SAMPLE_BITS] ? -diff : diff;

  // Difference, then square, then saturating accumulate: one pair per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.push;
      v2_r <= v1_r;
    end
    set1_r <= in_set_sel;
    mag1_r <= mag_full[SAMPLE_BITS-1:0];
    set2_r <= set1_r;
    sq2_r  <= mag1_r * mag1_r;
  end

  assign sum_sel = set2_r ? sum1_r : sum0_r;
  assign cnt_sel = set2_r ? cnt1_r : cnt0_r;
  assign room    = cnt_sel < CNT_W'(MAX_POINTS);
  assign sum_add = {1'b0, sum_sel} + {1'b0, SUM_W'(sq2_r)};
  assign sum_sat = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];

  always_comb begin
    sum0_nxt = sum0_r;
    sum1_nxt = sum1_r;
    cnt0_nxt = cnt0_r;
    cnt1_nxt = cnt1_r;
    if (cmd.op == OP_EMIT) begin
      sum0_nxt = '0;
      sum1_nxt = '0;
      cnt0_nxt = '0;
      cnt1_nxt = '0;
    end else if (v2_r && room) begin
      if (set2_r) begin
        sum1_nxt = sum_sat;
        cnt1_nxt = cnt_sel + 1'b1;
      end else begin
        sum0_nxt = sum_sat;
        cnt0_nxt = cnt_sel + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum0_r <= '0;
      sum1_r <= '0;
      cnt0_r <= '0;
      cnt1_r <= '0;
    end else begin
      sum0_r <= sum0_nxt;
      sum1_r <= sum1_nxt;
      cnt0_r <= cnt0_nxt;
      cnt1_r <= cnt1_nxt;
    end
  end

  assign sum0 = sum0_r;
  assign sum1 = sum1_r;
  assign cnt0 = cnt0_r;
  assign cnt1 = cnt1_r;

  assign acc_sts.pipe_busy = v1_r | v2_r;
  assign acc_sts.empty     = (cnt0_r == '0) || (cnt1_r == '0);
  assign acc_sts.s0_zero   = (sum0_r == '0);
  assign acc_sts.s1_zero   = (sum1_r == '0);

endmodule

// ----- rtl/core/grc_ratio.sv -----
module grc_ratio #(
  parameter int MAX_POINTS = grc_pkg::MAX_POINTS_DEF,
  localparam int CNT_W     = $clog2(MAX_POINTS + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  grc_pkg::grc_cmd_t            cmd,
  input  logic [grc_pkg::SUM_W-1:0]    sum0,
  input  logic [grc_pkg::SUM_W-1:0]    sum1,
  input  logic [CNT_W-1:0]             cnt0,
  input  logic [CNT_W-1:0]             cnt1,
  input  grc_pkg::grc_acc_sts_t        acc_sts,
  output logic                         div_sat,
  output logic [grc_pkg::RATIO_W-1:0]  out_ratio,
  output logic [grc_pkg::STATUS_W-1:0] out_status
);
  import grc_pkg::*;

  localparam int PROD_W = HALF_W + CNT_W;
  localparam int NUM_W  = SUM_W + CNT_W;

  logic [HALF_W-1:0] mul_a;
  logic [CNT_W-1:0]  mul_b;
  logic [PROD_W-1:0] prod_r;
  logic              pv_r;
  logic [1:0]        psel_r;

  // num_r = S0*n1, den_r = S1*n0. The dividend is num_r shifted up 32 bits.
  logic [NUM_W-1:0]  num_r, den_r, rem_r;
  logic [SUM_W-1:0]  lo_r, q_r;
  logic [NUM_W:0]    dtrial, ddiff;
  logic              dge;
  logic              sat_r;

  logic [HALF_W-1:0]  root_r, srem_r;
  logic [HALF_W+1:0]  st, strial, sdiff;
  logic               sge;

  logic [RATIO_W-1:0]  ratio_r;
  logic [STATUS_W-1:0] status_r;

  always_comb begin
    case (cmd.mul_sel)
      MSEL_S0_LO: mul_a = sum0[HALF_W-1:0];
      MSEL_S0_HI: mul_a = sum0[SUM_W-1:HALF_W];
      MSEL_S1_LO: mul_a = sum1[HALF_W-1:0];
      default:    mul_a = sum1[SUM_W-1:HALF_W];
    endcase
  end
  assign mul_b = cmd.mul_sel[1] ? cnt0 : cnt1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= (cmd.op == OP_MUL);
    end
    psel_r <= cmd.mul_sel;
    prod_r <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (pv_r) begin
      case (psel_r)
        MSEL_S0_LO: num_r <= NUM_W'(prod_r);
        MSEL_S0_HI: num_r <= num_r + {prod_r, {HALF_W{1'b0}}};
        MSEL_S1_LO: den_r <= NUM_W'(prod_r);
        default:    den_r <= den_r + {prod_r, {HALF_W{1'b0}}};
      endcase
    end
  end

  // Quotient overflows 64 bits when the upper part of the dividend reaches den.
  assign div_sat = NUM_W'(num_r[NUM_W-1:HALF_W]) >= den_r;

  assign dtrial = {rem_r, lo_r[SUM_W-1]};
  assign ddiff  = dtrial - {1'b0, den_r};
  assign dge    = dtrial >= {1'b0, den_r};

  assign st     = {srem_r, q_r[SUM_W-1 -: 2]};
  assign strial = {root_r, 2'b01};
  assign sdiff  = st - strial;
  assign sge    = st >= strial;

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_DIV_INIT: begin
        rem_r  <= NUM_W'(num_r[NUM_W-1:HALF_W]);
        lo_r   <= {num_r[HALF_W-1:0], {HALF_W{1'b0}}};
        q_r    <= '0;
        sat_r  <= div_sat;
        root_r <= '0;
        srem_r <= '0;
      end
      OP_DIV_STEP: begin
        rem_r <= dge ? ddiff[NUM_W-1:0] : dtrial[NUM_W-1:0];
        lo_r  <= {lo_r[SUM_W-2:0], 1'b0};
        q_r   <= {q_r[SUM_W-2:0], dge};
      end
      OP_SQRT_STEP: begin
        srem_r <= sge ? sdiff[HALF_W-1:0] : st[HALF_W-1:0];
        root_r <= {root_r[HALF_W-2:0], sge};
        q_r    <= {q_r[SUM_W-3:0], 2'b00};
      end
      OP_EMIT: begin
        if (acc_sts.empty) begin
          status_r <= ST_EMPTY;
          ratio_r  <= '0;
        end else if (acc_sts.s1_zero) begin
          status_r <= ST_DEN_ZERO;
          ratio_r  <= acc_sts.s0_zero ? '0 : RATIO_MAX;
        end else begin
          status_r <= ST_OK;
          ratio_r  <= sat_r ? RATIO_MAX : root_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_ratio  = ratio_r;
  assign out_status = status_r;

endmodule

// ----- rtl/core/grc_ctrl.sv -----
`include "grid_rms_convergence_ratio_top_assert.svh"

module grc_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_end_of_data,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  grc_pkg::grc_acc_sts_t acc_sts,
  input  logic                  div_sat,
  output grc_pkg::grc_cmd_t     cmd
);
  import grc_pkg::*;

  localparam logic [2:0] S_ACCUM = 3'd0;
  localparam logic [2:0] S_DRAIN = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_DIVI  = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_SQRT  = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [2:0]        state_r, state_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              push;

  assign in_stall = (state_r != S_ACCUM);
  assign push     = in_valid && !in_stall;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd.push      = push;
    cmd.op        = OP_NOP;
    cmd.mul_sel   = cnt_r[1:0];
    case (state_r)
      S_ACCUM: begin
        if (push && in_end_of_data) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!acc_sts.pipe_busy) begin
          cnt_nxt   = '0;
          state_nxt = (acc_sts.empty || acc_sts.s1_zero) ? S_EMIT : S_MUL;
        end
      end
      S_MUL: begin
        // A final pass with no product issued lets the last one land in its sum.
        if (cnt_r < STEP_W'(MUL_STEPS)) begin
          cmd.op  = OP_MUL;
          cnt_nxt = cnt_r + 1'b1;
        end else begin
          state_nxt = S_DIVI;
        end
      end
      S_DIVI: begin
        cmd.op    = OP_DIV_INIT;
        cnt_nxt   = '0;
        state_nxt = div_sat ? S_EMIT : S_DIV;
      end
      S_DIV: begin
        cmd.op  = OP_DIV_STEP;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == STEP_W'(DIV_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        cmd.op  = OP_SQRT_STEP;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == STEP_W'(SQRT_STEPS - 1)) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.op        = OP_EMIT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_ACCUM;
        end
      end
      default: begin
        state_nxt = S_ACCUM;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_ACCUM;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `GRC_ASSERT_NEXT(a_eod_drains, push && in_end_of_data, state_r == S_DRAIN,
                   "end of data did not start the drain")
  `GRC_ASSERT_IMP(a_emit_slot_free, cmd.op == OP_EMIT, !out_valid_r || !out_stall,
                  "result loaded over an untaken result")
  `GRC_ASSERT_NEXT(a_emit_shows, cmd.op == OP_EMIT, out_valid_r && state_r == S_ACCUM,
                   "loaded result not presented")
  `GRC_ASSERT_IMP(a_clear_quiet, cmd.op == OP_EMIT, !acc_sts.pipe_busy && !push,
                  "sums cleared while pairs were in flight")

endmodule

// ----- rtl/core/grid_rms_convergence_ratio_top.sv -----
// Grid refinement convergence ratio of two RMS differences.
// Input channel (in_valid / in_stall): one transaction carries one sample pair,
// a coarse value and the finer value at twice its index, both signed Q4.20,
// tagged by in_set_sel as set 0 (4h against 2h) or set 1 (2h against h).
// Pairs are taken one per cycle; each adds its squared difference and one to
// its set's count, both saturating. A pair arriving at a full set is dropped.
// A transaction with in_end_of_data set is folded in and then closes the data
// set: the input stalls while the pipeline drains, the cross products are
// formed on one shared 32-bit multiplier, a restoring divider yields 64
// quotient bits and a digit-by-digit square root gives 32 bits. Then the
// result transaction (out_ratio in unsigned Q16.16, out_status) is loaded;
// with an empty set or a zero second sum the arithmetic is skipped, and a
// quotient that overflows skips the divide and root and saturates the ratio.
// The divider and square root loops take the longest part of the close.
// Loading the result clears all sums and counts and input is taken again.
// The output register holds a result while out_stall is high; new pairs keep
// flowing in meanwhile, and a second result waits until the first is taken.
// Reset (rst_n low, synchronous) clears sums, counts and the output valid.
module grid_rms_convergence_ratio_top #(
  parameter int SAMPLE_BITS = grc_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_POINTS  = grc_pkg::MAX_POINTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_set_sel,
  input  logic signed [SAMPLE_BITS-1:0] in_coarse_val,
  input  logic signed [SAMPLE_BITS-1:0] in_fine_val,
  input  logic                         in_end_of_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [grc_pkg::RATIO_W-1:0]  out_ratio,
  output logic [grc_pkg::STATUS_W-1:0] out_status
);
  import grc_pkg::*;

  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  grc_cmd_t         cmd;
  grc_acc_sts_t     acc_sts;
  logic             div_sat;
  logic [SUM_W-1:0] sum0, sum1;
  logic [CNT_W-1:0] cnt0, cnt1;

  // Sequencer: accepts pairs, runs the end-of-set arithmetic, owns out_valid.
  grc_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_end_of_data (in_end_of_data),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .acc_sts        (acc_sts),
    .div_sat        (div_sat),
    .cmd            (cmd)
  );

  // Per-set sums of squared differences and pair counts.
  grc_accum #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_POINTS  (MAX_POINTS)
  ) u_accum (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_set_sel    (in_set_sel),
    .in_coarse_val (in_coarse_val),
    .in_fine_val   (in_fine_val),
    .sum0          (sum0),
    .sum1          (sum1),
    .cnt0          (cnt0),
    .cnt1          (cnt1),
    .acc_sts       (acc_sts)
  );

  // Cross multiply, divide, square root and the result register.
  grc_ratio #(
    .MAX_POINTS (MAX_POINTS)
  ) u_ratio (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sum0       (sum0),
    .sum1       (sum1),
    .cnt0       (cnt0),
    .cnt1       (cnt1),
    .acc_sts    (acc_sts),
    .div_sat    (div_sat),
    .out_ratio  (out_ratio),
    .out_status (out_status)
  );

endmodule

// ----- verif/tb_top.sv -----
// Testbench for the grid refinement convergence ratio block.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import grc_pkg::*;

  // The clock period is 4 ns; RESET_CYCLES sets the reset hold.
  localparam int CLK_PERIOD = 4;
  localparam int RESET_CYCLES = 6;

  // Block sizes as the block is built with its default parameters.
  localparam int SAMPLE_W = SAMPLE_BITS_DEF;
  localparam int MAX_PAIRS = MAX_POINTS_DEF;

  // The tail wait after the last result is longer than the longest data set
  // close, with margin. The watchdog limit on cycles with no transaction on
  // either channel is far above one close, the output backpressure hold below
  // and any random stall streak.
  localparam int DRAIN_CYCLES = 200;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES = 500;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};

  // One expected result transaction.
  typedef struct {
    logic [RATIO_W-1:0]  ratio;
    logic [STATUS_W-1:0] status;
  } rms_ratio_t;

  // Every block input gets a known value from time zero.
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_set_sel = 1'b0;
  logic signed [SAMPLE_W-1:0] in_coarse_val = '0;
  logic signed [SAMPLE_W-1:0] in_fine_val = '0;
  logic in_end_of_data = 1'b0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  logic [RATIO_W-1:0] out_ratio;
  logic [STATUS_W-1:0] out_status;

  // The predictor keeps its own copy of the per-set sums and counts. The
  // expected results wait here in order until the block hands them out.
  logic [SUM_W-1:0] sq_sum [2];
  int unsigned pair_cnt [2];
  rms_ratio_t ratio_expect_q [$];

  // Idle rates in percent. The main sequence sets them for each phase.
  int send_gap_pct = 0;
  int recv_stall_pct = 0;

  // The main sequence asks for a long receiver hold by bumping hold_id. The
  // receiver process counts the hold down itself.
  int hold_id = 0;
  int hold_len = 0;
  int hold_seen = 0;
  int hold_left = 0;

  int pairs_sent = 0;
  int sets_closed = 0;
  int results_checked = 0;
  int fail_count = 0;
  int quiet_cycles = 0;

  grid_rms_convergence_ratio_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_set_sel     (in_set_sel),
    .in_coarse_val  (in_coarse_val),
    .in_fine_val    (in_fine_val),
    .in_end_of_data (in_end_of_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_ratio      (out_ratio),
    .out_status     (out_status)
  );

  always #(CLK_PERIOD / 2.0) clk = ~clk;

  // The ratio is floor(sqrt(floor(S0 * n1 * 2^32 / (S1 * n0)))). This equals
  // floor(2^16 * sqrt(S0/n0) / sqrt(S1/n1)) exactly. A quotient that does not
  // fit in 64 bits saturates the ratio. The square root is built one bit at a
  // time from the top. A trial below 2^32 squares to less than 2^64.
  function automatic logic [RATIO_W-1:0] rms_quotient_root(
    input logic [SUM_W-1:0] s0,
    input logic [SUM_W-1:0] s1,
    input int unsigned n0,
    input int unsigned n1
  );
    logic [127:0] num;
    logic [127:0] den;
    logic [127:0] quot;
    logic [63:0] root;
    logic [63:0] trial;
    num = ({64'd0, s0} * 128'(n1)) << 32;
    den = {64'd0, s1} * 128'(n0);
    quot = num / den;
    if (quot[127:64] != '0) begin
      return RATIO_MAX;
    end
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= quot[63:0]) begin
        root = trial;
      end
    end
    return root[RATIO_W-1:0];
  endfunction

  // Fold one accepted pair into the predicted state. A closing pair also
  // produces the expected result, and then the state is cleared.
  function automatic void fold_pair(
    input bit sel,
    input logic signed [SAMPLE_W-1:0] c,
    input logic signed [SAMPLE_W-1:0] f,
    input bit eod
  );
    longint diff;
    logic [SUM_W-1:0] sq;
    logic [SUM_W:0] total;
    rms_ratio_t res;
    diff = longint'(c) - longint'(f);
    if (diff < 0) begin
      diff = -diff;
    end
    sq = 64'(diff) * 64'(diff);
    // A pair that arrives at a full set is dropped. Its sum and count stay.
    if (pair_cnt[sel] < MAX_PAIRS) begin
      total = {1'b0, sq_sum[sel]} + {1'b0, sq};
      sq_sum[sel] = total[SUM_W] ? '1 : total[SUM_W-1:0];
      pair_cnt[sel]++;
    end
    if (!eod) begin
      return;
    end
    if (pair_cnt[0] == 0 || pair_cnt[1] == 0) begin
      res.status = ST_EMPTY;
      res.ratio = '0;
    end else if (sq_sum[1] == '0) begin
      res.status = ST_DEN_ZERO;
      res.ratio = (sq_sum[0] != '0) ? RATIO_MAX : '0;
    end else begin
      res.status = ST_OK;
      res.ratio = rms_quotient_root(sq_sum[0], sq_sum[1], pair_cnt[0], pair_cnt[1]);
    end
    ratio_expect_q.push_back(res);
    sets_closed++;
    sq_sum[0] = '0;
    sq_sum[1] = '0;
    pair_cnt[0] = 0;
    pair_cnt[1] = 0;
  endfunction

  // Pick a pair whose difference is at most 2^k in magnitude. A negative k
  // gives two equal samples. When coarse minus the offset leaves the sample
  // range, the offset is added instead, which keeps the same magnitude.
  function automatic void pick_pair(
    input int k,
    output logic signed [SAMPLE_W-1:0] c,
    output logic signed [SAMPLE_W-1:0] f
  );
    longint span;
    longint offs;
    longint fv;
    c = SAMPLE_W'($urandom);
    if (k < 0) begin
      f = c;
      return;
    end
    span = longint'(1) << k;
    offs = longint'($urandom_range(32'(2 * span))) - span;
    fv = longint'(c) - offs;
    if (fv > longint'(SAMPLE_MAX) || fv < longint'(SAMPLE_MIN)) begin
      fv = longint'(c) + offs;
    end
    f = fv[SAMPLE_W-1:0];
  endfunction

  // Send one pair transaction. The task is entered just after a falling edge.
  // It may leave in_valid low for random cycles first. Then it holds the
  // payload steady until the rising edge that takes it. In_valid stays high
  // on return, so back-to-back pairs need only one assignment per edge.
  task automatic send_pair(
    input bit sel,
    input logic signed [SAMPLE_W-1:0] c,
    input logic signed [SAMPLE_W-1:0] f,
    input bit eod
  );
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_set_sel <= sel;
    in_coarse_val <= c;
    in_fine_val <= f;
    in_end_of_data <= eod;
    do begin
      @(posedge clk);
    end while (in_stall);
    fold_pair(sel, c, f, eod);
    pairs_sent++;
    @(negedge clk);
  endtask

  // This test covers full-scale differences in both directions, the pair with
  // both samples at the maximum, and a set pair with equal RMS values. The
  // equal RMS values give a ratio of exactly 1.0.
  task automatic test_extremes;
    send_pair(1'b0, SAMPLE_MIN, SAMPLE_MAX, 1'b0);
    send_pair(1'b0, SAMPLE_MAX, SAMPLE_MIN, 1'b0);
    send_pair(1'b1, SAMPLE_MAX, SAMPLE_MAX, 1'b0);
    send_pair(1'b1, SAMPLE_MIN, '0, 1'b1);
    send_pair(1'b0, 24'sd1, '0, 1'b0);
    send_pair(1'b1, '0, 24'sd1, 1'b1);
  endtask

  // Data sets that close with one of the two sets empty.
  task automatic test_empty_set;
    send_pair(1'b0, SAMPLE_MAX, '0, 1'b1);
    send_pair(1'b1, SAMPLE_MIN, '0, 1'b1);
    send_pair(1'b1, 24'sd100, -24'sd100, 1'b0);
    send_pair(1'b1, '0, '0, 1'b0);
    send_pair(1'b1, -24'sd7, 24'sd3, 1'b1);
  endtask

  // In this test the second set has pairs but no error at all. The first set
  // has error, and then none.
  task automatic test_zero_second_rms;
    send_pair(1'b0, 24'sd5000, -24'sd5000, 1'b0);
    send_pair(1'b1, SAMPLE_MIN, SAMPLE_MIN, 1'b0);
    send_pair(1'b1, SAMPLE_MAX, SAMPLE_MAX, 1'b1);
    send_pair(1'b0, 24'sd42, 24'sd42, 1'b0);
    send_pair(1'b1, '0, '0, 1'b0);
    send_pair(1'b0, SAMPLE_MIN, SAMPLE_MIN, 1'b1);
  endtask

  // A maximal first error against a one-LSB second error overflows the
  // quotient, so the ratio saturates.
  task automatic test_ratio_saturation;
    send_pair(1'b1, '0, -24'sd1, 1'b0);
    send_pair(1'b0, SAMPLE_MIN, SAMPLE_MAX, 1'b1);
  endtask

  // Random data sets. Most are short and shaped like a real refinement study,
  // where the second set has the smaller error. Some sets have only one set
  // tag, some have an exact second set, and some carry unrelated or
  // full-scale samples.
  task automatic test_random_sets(input int n_items);
    int sent;
    int len;
    int k0;
    int k1;
    int shape;
    bit sel;
    bit only_sel;
    logic signed [SAMPLE_W-1:0] c;
    logic signed [SAMPLE_W-1:0] f;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(80, 20) : $urandom_range(16, 1);
      k0 = $urandom_range(23);
      k1 = ($urandom_range(3) == 0) ? $urandom_range(23) : $urandom_range(k0);
      shape = $urandom_range(19);
      only_sel = 1'($urandom_range(1));
      for (int i = 0; i < len; i++) begin
        sel = (shape == 0) ? only_sel : 1'($urandom_range(1));
        if (shape == 2 || $urandom_range(15) == 0) begin
          c = SAMPLE_W'($urandom);
          f = SAMPLE_W'($urandom);
        end else if ($urandom_range(31) == 0) begin
          c = $urandom_range(1) ? SAMPLE_MIN : SAMPLE_MAX;
          f = $urandom_range(1) ? SAMPLE_MIN : SAMPLE_MAX;
        end else begin
          pick_pair(sel ? ((shape == 1) ? -1 : k1) : k0, c, f);
        end
        send_pair(sel, c, f, i == len - 1);
      end
      sent += len;
    end
  endtask

  // The receiver holds off for a long stretch while short data sets keep
  // arriving. One result sits in the output register and a second one waits
  // behind it, so the block has to stall its input until the hold ends.
  task automatic test_output_backpressure;
    logic signed [SAMPLE_W-1:0] c;
    logic signed [SAMPLE_W-1:0] f;
    hold_len = HOLD_CYCLES;
    hold_id++;
    for (int s = 0; s < 8; s++) begin
      for (int i = 0; i < 4; i++) begin
        pick_pair($urandom_range(20), c, f);
        send_pair(1'(i), c, f, i == 3);
      end
    end
  endtask

  // Result side. Out_stall changes on the falling edge. A requested hold wins
  // over the random stall rate.
  always @(negedge clk) begin
    if (hold_id != hold_seen) begin
      hold_seen = hold_id;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Every result transaction taken at a rising edge is compared with the
  // oldest expected result, one field at a time.
  always @(posedge clk) begin
    rms_ratio_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (ratio_expect_q.size() == 0) begin
        $error("result with none expected: ratio %h status %0d", out_ratio, out_status);
        fail_count++;
      end else begin
        exp_res = ratio_expect_q.pop_front();
        results_checked++;
        if (out_ratio !== exp_res.ratio) begin
          $error("out_ratio mismatch: expected %h, actual %h", exp_res.ratio, out_ratio);
          fail_count++;
        end
        if (out_status !== exp_res.status) begin
          $error("out_status mismatch: expected %0d, actual %0d", exp_res.status, out_status);
          fail_count++;
        end
      end
    end
  end

  // The watchdog counts cycles with no transaction on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  // Main sequence. Reset is applied once. The directed tests and the first
  // random phase run with a rare sender gap and a busy receiver. The second
  // phase swaps the two rates, and the last phase has no idling at all. The
  // long output hold runs at the end, with neither side idling otherwise.
  initial begin
    sq_sum[0] = '0;
    sq_sum[1] = '0;
    pair_cnt[0] = 0;
    pair_cnt[1] = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_gap_pct = 10;
    recv_stall_pct = 78;
    test_extremes();
    test_empty_set();
    test_zero_second_rms();
    test_ratio_saturation();
    test_random_sets(350);

    send_gap_pct = 78;
    recv_stall_pct = 10;
    test_random_sets(350);

    send_gap_pct = 0;
    recv_stall_pct = 0;
    test_random_sets(350);
    test_output_backpressure();

    in_valid <= 1'b0;
    wait (ratio_expect_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d pairs in %0d data sets, %0d results compared.",
             pairs_sent, sets_closed, results_checked);
    $display("Included empty sets, exact second sets, extreme samples, saturation and a long hold.");
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- grid_rms_convergence_ratio_top.f -----
+incdir+rtl/core
rtl/core/grc_pkg.sv
rtl/core/grc_accum.sv
rtl/core/grc_ratio.sv
rtl/core/grc_ctrl.sv
rtl/core/grid_rms_convergence_ratio_top.sv
verif/tb_top.sv
